### rtl/core/rgb2yuv_pkg.sv
`default_nettype none

package rgb2yuv_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;
    localparam int HEIGHT_LIMIT      = 2048;
    localparam int ROW_W             = 11;
    localparam int CFG_W             = 12;
    localparam int CFG_INDEX_W       = 1;
    localparam int PIX_W             = 8;
    localparam int SUM2_W            = 9;
    localparam int SUM4_W            = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic [15:0] Y_KR   = 16'd77;
    localparam logic [15:0] Y_KG   = 16'd150;
    localparam logic [15:0] Y_KB   = 16'd29;
    localparam logic [15:0] Y_ROUND = 16'd128;

    localparam logic signed [8:0] CB_KR = -9'sd43;
    localparam logic signed [8:0] CB_KG = -9'sd85;
    localparam logic signed [8:0] CB_KB = 9'sd128;
    localparam logic signed [8:0] CR_KR = 9'sd128;
    localparam logic signed [8:0] CR_KG = -9'sd107;
    localparam logic signed [8:0] CR_KB = -9'sd21;

    // rounding plus the 128 offset moved ahead of the shift
    localparam logic signed [19:0] C_BIAS = 20'sd131583;

    // r in the low bits, then g, then b
    typedef struct packed {
        logic [SUM2_W-1:0] b;
        logic [SUM2_W-1:0] g;
        logic [SUM2_W-1:0] r;
    } sums_t;

    localparam int SUMS_W = $bits(sums_t);

    function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
        logic [15:0] s;
        s = Y_KR * 16'(r) + Y_KG * 16'(g) + Y_KB * 16'(b) + Y_ROUND;
        return s[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] chroma_of(input logic [SUM4_W-1:0] r4,
                                                   input logic [SUM4_W-1:0] g4,
                                                   input logic [SUM4_W-1:0] b4,
                                                   input logic signed [8:0] kr,
                                                   input logic signed [8:0] kg,
                                                   input logic signed [8:0] kb);
        logic signed [19:0] v;
        v = signed'({10'd0, r4}) * 20'(kr)
          + signed'({10'd0, g4}) * 20'(kg)
          + signed'({10'd0, b4}) * 20'(kb)
          + C_BIAS;
        return v[19] ? 8'd0 : v[17:10];
    endfunction

endpackage

`default_nettype wire

### rtl/core/rgb2yuv_if.sv
`default_nettype none

interface rgb2yuv_pix_if;
    import rgb2yuv_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb2yuv_res_if;
    import rgb2yuv_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] blue_diff;
    logic [PIX_W-1:0] red_diff;
    logic             frame_end;

    modport source (output valid, output luma, output chroma_valid, output blue_diff,
                    output red_diff, output frame_end, input ready);
    modport sink   (input valid, input luma, input chroma_valid, input blue_diff,
                    input red_diff, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/core/rgb2yuv_ram.sv
`default_nettype none

module rgb2yuv_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

`default_nettype wire

### rtl/core/rgb_to_yuv420_converter_core.sv
`default_nettype none

// RGB raster to YCbCr 4:2:0 (full range). One pixel request is taken every clock unless
// stalled, and each pixel gives one result through the three stages: luma always, Cb and
// Cr on the odd column of each odd row, frame_end on the last pixel. Even-row pair sums
// sit in one line RAM of MAX_WIDTH/2 entries, written at the even row and read one line
// later; its one write and one read port a cycle set the rate of one pixel per clock.
// Stalls on the result side back up through the stages to the request side. Width and
// height are written through the config port between frames; their low bit is ignored.
module rgb_to_yuv420_converter_core #(
    parameter int MAX_WIDTH = rgb2yuv_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rgb2yuv_pkg::CFG_W-1:0]       cfg_data,
    rgb2yuv_pix_if.sink                              pixel_in,
    rgb2yuv_res_if.source                            pixel_out
);
    import rgb2yuv_pkg::*;

    localparam int COL_W    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH    = MAX_WIDTH / 2;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma;
        logic             frame_end;
        sums_t            pair;
    } stage1_t;

    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic              chroma;
        logic              frame_end;
        logic [SUM4_W-1:0] r4;
        logic [SUM4_W-1:0] g4;
        logic [SUM4_W-1:0] b4;
    } stage2_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] blue_diff;
        logic [PIX_W-1:0] red_diff;
        logic             frame_end;
    } result_t;

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [COL_W-1:0] column_count_reg, column_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    sums_t            pair_sums_reg, pair_sums_next;

    logic    s1_valid_reg, s1_valid_next;
    logic    s2_valid_reg, s2_valid_next;
    logic    out_valid_reg, out_valid_next;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    result_t out_reg, out_next;

    logic              out_free, s2_free, s1_free, accept;
    logic [CFG_W-1:0]  w_masked, h_masked, h_eff;
    logic [13:0]       w_eff;
    logic              last_col, last_row;
    sums_t             pair_now, line_sums;
    logic [ADDR_W-1:0] store_addr;
    logic              store_wr, store_rd;
    logic [SUMS_W-1:0] store_rd_data;

    // frame geometry
    always_comb
    begin
        w_masked = frame_width_reg & ~12'd1;
        h_masked = frame_height_reg & ~12'd1;
        if (w_masked < 12'd2)
        begin
            w_eff = 14'd2;
        end
        else if (32'(w_masked) > MAX_WIDTH)
        begin
            w_eff = 14'(MAX_EVEN);
        end
        else
        begin
            w_eff = 14'(w_masked);
        end
        if (h_masked < 12'd2)
        begin
            h_eff = 12'd2;
        end
        else if (h_masked > 12'(HEIGHT_LIMIT))
        begin
            h_eff = 12'(HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = h_masked;
        end
        last_col = 14'(column_count_reg) >= (w_eff - 14'd1);
        last_row = 12'(row_count_reg) >= (h_eff - 12'd1);
    end

    // pipeline flow
    assign out_free       = !out_valid_reg || pixel_out.ready;
    assign s2_free        = !s2_valid_reg || out_free;
    assign s1_free        = !s1_valid_reg || s2_free;
    assign pixel_in.ready = s1_free;
    assign accept         = pixel_in.valid && s1_free;

    // line store access
    always_comb
    begin
        pair_now.r = pair_sums_reg.r + SUM2_W'(pixel_in.red);
        pair_now.g = pair_sums_reg.g + SUM2_W'(pixel_in.green);
        pair_now.b = pair_sums_reg.b + SUM2_W'(pixel_in.blue);
        store_addr = ADDR_W'(column_count_reg >> 1);
        store_wr   = accept && column_count_reg[0] && !row_count_reg[0];
        store_rd   = accept && column_count_reg[0] && row_count_reg[0];
    end

    rgb2yuv_ram #(
        .WIDTH (SUMS_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (store_addr),
        .wr_data (pair_now),
        .rd_en   (store_rd),
        .rd_addr (store_addr),
        .rd_data (store_rd_data)
    );

    assign line_sums = sums_t'(store_rd_data);

    // config and counters
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        pair_sums_next    = pair_sums_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
            endcase
        end
        if (accept)
        begin
            if (!column_count_reg[0])
            begin
                pair_sums_next.r = SUM2_W'(pixel_in.red);
                pair_sums_next.g = SUM2_W'(pixel_in.green);
                pair_sums_next.b = SUM2_W'(pixel_in.blue);
            end
            if (last_col)
            begin
                column_count_next = '0;
                row_count_next    = last_row ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                column_count_next = column_count_reg + 1'b1;
            end
        end
    end

    // stage contents
    always_comb
    begin
        s1_valid_next  = s1_free ? pixel_in.valid : s1_valid_reg;
        s2_valid_next  = s2_free ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_free ? s2_valid_reg : out_valid_reg;

        s1_next           = s1_reg;
        s1_next.luma      = luma_of(pixel_in.red, pixel_in.green, pixel_in.blue);
        s1_next.chroma    = column_count_reg[0] && row_count_reg[0];
        s1_next.frame_end = last_col && last_row;
        s1_next.pair      = pair_now;

        s2_next.luma      = s1_reg.luma;
        s2_next.chroma    = s1_reg.chroma;
        s2_next.frame_end = s1_reg.frame_end;
        s2_next.r4        = SUM4_W'(s1_reg.pair.r) + SUM4_W'(line_sums.r);
        s2_next.g4        = SUM4_W'(s1_reg.pair.g) + SUM4_W'(line_sums.g);
        s2_next.b4        = SUM4_W'(s1_reg.pair.b) + SUM4_W'(line_sums.b);

        out_next.luma         = s2_reg.luma;
        out_next.chroma_valid = s2_reg.chroma;
        out_next.frame_end    = s2_reg.frame_end;
        out_next.blue_diff    = s2_reg.chroma
            ? chroma_of(s2_reg.r4, s2_reg.g4, s2_reg.b4, CB_KR, CB_KG, CB_KB) : 8'd0;
        out_next.red_diff     = s2_reg.chroma
            ? chroma_of(s2_reg.r4, s2_reg.g4, s2_reg.b4, CR_KR, CR_KG, CR_KB) : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pair_sums_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            pair_sums_reg    <= pair_sums_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_reg <= s1_next;
        end
        if (s2_free)
        begin
            s2_reg <= s2_next;
        end
        if (out_free)
        begin
            out_reg <= out_next;
        end
    end

    assign pixel_out.valid        = out_valid_reg;
    assign pixel_out.luma         = out_reg.luma;
    assign pixel_out.chroma_valid = out_reg.chroma_valid;
    assign pixel_out.blue_diff    = out_reg.blue_diff;
    assign pixel_out.red_diff     = out_reg.red_diff;
    assign pixel_out.frame_end    = out_reg.frame_end;

`ifndef ASSERT_OFF
    // line store read data must hold while its request waits in stage one
    a_store_read_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |-> !store_rd)
        else $error("line store read while stage one is stalled");

    // last pixel of the frame returns the counters to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col && last_row) |=> (column_count_reg == '0 && row_count_reg == '0))
        else $error("counters did not wrap at frame end");

    // column count always addresses inside the line store
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(column_count_reg) < MAX_WIDTH)
        else $error("column count out of range");
`endif

endmodule

`default_nettype wire
